/* rtl/mesh_flood_relay_dedup_macros.svh */
// Assertion macros shared by the flood relay modules.
// Each one expects signals named clock and reset in the module that uses it.
`ifndef MESH_FLOOD_RELAY_DEDUP_MACROS_SVH
`define MESH_FLOOD_RELAY_DEDUP_MACROS_SVH

`define MFRD_ASSERT_BASE(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("mesh_flood_relay_dedup: assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define MFRD_ASSERT_IMP(lbl, ante, cons) `MFRD_ASSERT_BASE(lbl, (ante) |-> (cons))

// Consequent must hold in the cycle after the antecedent.
`define MFRD_ASSERT_NEXT(lbl, ante, cons) `MFRD_ASSERT_BASE(lbl, (ante) |=> (cons))

`endif

/* rtl/mfrd_pkg.sv */
`default_nettype none

package mfrd_pkg;

   localparam int CACHE_DEPTH = 32;
   localparam int PTR_W       = $clog2(CACHE_DEPTH);
   localparam int ORIGIN_W    = 32;
   localparam int SEQ_W       = 16;
   localparam int TTL_W       = 8;
   localparam int TIME_W      = 32;
   localparam int DELAY_W     = 9;
   localparam int FUNC_W      = 2;
   localparam int ENTRY_W     = ORIGIN_W + SEQ_W;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 32;

   localparam logic [FUNC_W-1:0] FUNC_RECEIVE   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ORIGINATE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_POLL      = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_ID   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOP_LIMIT = 1'b1;

   localparam logic [ORIGIN_W-1:0] NODE_ID_RESET   = 32'd1;
   localparam logic [TTL_W-1:0]    HOP_LIMIT_RESET = 8'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_COMMIT
   } mfrd_state_type;

   typedef struct packed {
      logic accept;
      logic issue;
      logic commit;
   } mfrd_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_free;
   } mfrd_sts_type;

endpackage

`default_nettype wire

/* rtl/mfrd_ram.sv */
`default_nettype none

module mfrd_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/mfrd_ctrl.sv */
`default_nettype none
`include "mesh_flood_relay_dedup_macros.svh"

module mfrd_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire mfrd_pkg::mfrd_sts_type sts,
   output mfrd_pkg::mfrd_cmd_type     cmd
);

   mfrd_pkg::mfrd_state_type state_ff;
   mfrd_pkg::mfrd_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfrd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mfrd_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = mfrd_pkg::ST_ISSUE;
            end
         end
         mfrd_pkg::ST_ISSUE: begin
            if (sts.scan_last) begin
               state_in = mfrd_pkg::ST_DRAIN;
            end
         end
         mfrd_pkg::ST_DRAIN: begin
            state_in = mfrd_pkg::ST_COMMIT;
         end
         mfrd_pkg::ST_COMMIT: begin
            if (sts.out_free) begin
               state_in = mfrd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mfrd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready  = (state_ff == mfrd_pkg::ST_IDLE);
      cmd.accept = req_ready && req_valid;
      cmd.issue  = (state_ff == mfrd_pkg::ST_ISSUE);
      cmd.commit = (state_ff == mfrd_pkg::ST_COMMIT) && sts.out_free;
   end

   `MFRD_ASSERT_IMP(a_commit_needs_slot, cmd.commit, sts.out_free)
   `MFRD_ASSERT_NEXT(a_accept_starts_scan, cmd.accept, state_ff == mfrd_pkg::ST_ISSUE)
   `MFRD_ASSERT_NEXT(a_last_read_drains, cmd.issue && sts.scan_last,
                     state_ff == mfrd_pkg::ST_DRAIN)

endmodule

`default_nettype wire

/* rtl/mfrd_dp.sv */
`default_nettype none
`include "mesh_flood_relay_dedup_macros.svh"

module mfrd_dp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire mfrd_pkg::mfrd_cmd_type             cmd,
   output mfrd_pkg::mfrd_sts_type                  sts,
   input  wire logic [mfrd_pkg::FUNC_W-1:0]        req_func,
   input  wire logic [mfrd_pkg::ORIGIN_W-1:0]      req_pkt_origin,
   input  wire logic [mfrd_pkg::SEQ_W-1:0]         req_pkt_seq,
   input  wire logic [mfrd_pkg::TTL_W-1:0]         req_pkt_ttl,
   input  wire logic [mfrd_pkg::TIME_W-1:0]        req_now_ms,
   input  wire logic [mfrd_pkg::DELAY_W-1:0]       req_relay_delay,
   input  wire logic                               csr_write,
   input  wire logic [mfrd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [mfrd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_valid,
   output logic                                    rsp_send_valid,
   output logic      [mfrd_pkg::ORIGIN_W-1:0]      rsp_send_origin,
   output logic      [mfrd_pkg::ORIGIN_W-1:0]      rsp_send_sender,
   output logic      [mfrd_pkg::SEQ_W-1:0]         rsp_send_seq,
   output logic      [mfrd_pkg::TTL_W-1:0]         rsp_send_ttl,
   output logic                                    rsp_duplicate,
   output logic                                    rsp_cancelled,
   output logic                                    rsp_accepted
);

   // Configuration registers.
   logic [mfrd_pkg::ORIGIN_W-1:0] node_id_ff;
   logic [mfrd_pkg::TTL_W-1:0]    hop_limit_ff;

   // Transaction being worked on.
   logic [mfrd_pkg::FUNC_W-1:0]   func_ff;
   logic [mfrd_pkg::ORIGIN_W-1:0] key_origin_ff;
   logic [mfrd_pkg::SEQ_W-1:0]    key_seq_ff;
   logic [mfrd_pkg::TTL_W-1:0]    ttl_ff;
   logic [mfrd_pkg::TIME_W-1:0]   now_ff;
   logic [mfrd_pkg::DELAY_W-1:0]  delay_ff;

   // Pending relay.
   logic                          pend_valid_ff, pend_valid_in;
   logic [mfrd_pkg::ORIGIN_W-1:0] pend_origin_ff, pend_origin_in;
   logic [mfrd_pkg::SEQ_W-1:0]    pend_seq_ff, pend_seq_in;
   logic [mfrd_pkg::TTL_W-1:0]    pend_ttl_ff, pend_ttl_in;
   logic [mfrd_pkg::TIME_W-1:0]   pend_deadline_ff, pend_deadline_in;

   logic [mfrd_pkg::SEQ_W-1:0]    next_seq_ff, next_seq_in;
   logic [mfrd_pkg::PTR_W-1:0]    insert_ptr_ff;

   // Cache scan.
   logic [mfrd_pkg::CACHE_DEPTH-1:0] entry_valid_ff;
   logic [mfrd_pkg::PTR_W-1:0]       scan_ff;
   logic                             rd_vld_ff;
   logic                             cmp_en_ff;
   logic                             hit_ff;
   logic [mfrd_pkg::ENTRY_W-1:0]     rd_data;
   logic [mfrd_pkg::ENTRY_W-1:0]     entry;
   logic                             match;

   // Cache insertion.
   logic                          rec_en;
   logic [mfrd_pkg::ORIGIN_W-1:0] rec_origin;
   logic [mfrd_pkg::SEQ_W-1:0]    rec_seq;

   // Result register.
   logic                          rsp_valid_ff;
   logic                          send_valid_ff, send_valid_in;
   logic [mfrd_pkg::ORIGIN_W-1:0] send_origin_ff, send_origin_in;
   logic [mfrd_pkg::ORIGIN_W-1:0] send_sender_ff, send_sender_in;
   logic [mfrd_pkg::SEQ_W-1:0]    send_seq_ff, send_seq_in;
   logic [mfrd_pkg::TTL_W-1:0]    send_ttl_ff, send_ttl_in;
   logic                          duplicate_ff, duplicate_in;
   logic                          cancelled_ff, cancelled_in;
   logic                          accepted_ff, accepted_in;

   assign sts.scan_last = (scan_ff == mfrd_pkg::PTR_W'(mfrd_pkg::CACHE_DEPTH - 1));
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff   <= mfrd_pkg::NODE_ID_RESET;
         hop_limit_ff <= mfrd_pkg::HOP_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            mfrd_pkg::CSR_NODE_ID:   node_id_ff   <= csr_wdata;
            mfrd_pkg::CSR_HOP_LIMIT: hop_limit_ff <= csr_wdata[mfrd_pkg::TTL_W-1:0];
            default: ;
         endcase
      end
   end

   // The scan key is the received pair, or for an originate or a poll the pending pair.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff  <= req_func;
         ttl_ff   <= req_pkt_ttl;
         now_ff   <= req_now_ms;
         delay_ff <= req_relay_delay;
         if (req_func == mfrd_pkg::FUNC_RECEIVE) begin
            key_origin_ff <= req_pkt_origin;
            key_seq_ff    <= req_pkt_seq;
         end else begin
            key_origin_ff <= pend_origin_ff;
            key_seq_ff    <= pend_seq_ff;
         end
      end
   end

   mfrd_ram #(
      .WIDTH (mfrd_pkg::ENTRY_W),
      .DEPTH (mfrd_pkg::CACHE_DEPTH)
   ) u_cache (
      .clock   (clock),
      .wr_en   (rec_en),
      .wr_addr (insert_ptr_ff),
      .wr_data ({rec_origin, rec_seq}),
      .rd_addr (scan_ff),
      .rd_data (rd_data)
   );

   // An entry never written reads as the all-zero pair.
   assign entry = rd_vld_ff ? rd_data : '0;
   assign match = (entry == {key_origin_ff, key_seq_ff});

   always_ff @(posedge clock) begin
      rd_vld_ff <= entry_valid_ff[scan_ff];
      if (reset) begin
         scan_ff        <= '0;
         cmp_en_ff      <= 1'b0;
         hit_ff         <= 1'b0;
         entry_valid_ff <= '0;
         insert_ptr_ff  <= '0;
      end else begin
         cmp_en_ff <= cmd.issue;
         if (cmd.accept) begin
            scan_ff <= '0;
            hit_ff  <= 1'b0;
         end else begin
            if (cmd.issue) begin
               scan_ff <= sts.scan_last ? '0 : scan_ff + 1'b1;
            end
            if (cmp_en_ff && match) begin
               hit_ff <= 1'b1;
            end
         end
         if (rec_en) begin
            entry_valid_ff[insert_ptr_ff] <= 1'b1;
            if (insert_ptr_ff == mfrd_pkg::PTR_W'(mfrd_pkg::CACHE_DEPTH - 1)) begin
               insert_ptr_ff <= '0;
            end else begin
               insert_ptr_ff <= insert_ptr_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      pend_valid_in    = pend_valid_ff;
      pend_origin_in   = pend_origin_ff;
      pend_seq_in      = pend_seq_ff;
      pend_ttl_in      = pend_ttl_ff;
      pend_deadline_in = pend_deadline_ff;
      next_seq_in      = next_seq_ff;
      rec_en           = 1'b0;
      rec_origin       = key_origin_ff;
      rec_seq          = key_seq_ff;
      send_valid_in    = 1'b0;
      send_origin_in   = '0;
      send_sender_in   = '0;
      send_seq_in      = '0;
      send_ttl_in      = '0;
      duplicate_in     = 1'b0;
      cancelled_in     = 1'b0;
      accepted_in      = 1'b0;
      if (cmd.commit) begin
         unique case (func_ff)
            mfrd_pkg::FUNC_RECEIVE: begin
               if (hit_ff) begin
                  duplicate_in = 1'b1;
                  if (pend_valid_ff && pend_origin_ff == key_origin_ff &&
                      pend_seq_ff == key_seq_ff) begin
                     pend_valid_in = 1'b0;
                     cancelled_in  = 1'b1;
                  end
               end else begin
                  pend_valid_in    = 1'b1;
                  pend_origin_in   = key_origin_ff;
                  pend_seq_in      = key_seq_ff;
                  pend_ttl_in      = ttl_ff;
                  pend_deadline_in = now_ff + mfrd_pkg::TIME_W'(delay_ff);
                  accepted_in      = 1'b1;
               end
            end
            mfrd_pkg::FUNC_ORIGINATE: begin
               next_seq_in    = next_seq_ff + 1'b1;
               rec_en         = 1'b1;
               rec_origin     = node_id_ff;
               rec_seq        = next_seq_ff;
               send_valid_in  = 1'b1;
               send_origin_in = node_id_ff;
               send_sender_in = node_id_ff;
               send_seq_in    = next_seq_ff;
               send_ttl_in    = hop_limit_ff;
            end
            mfrd_pkg::FUNC_POLL: begin
               if (pend_valid_ff && now_ff >= pend_deadline_ff) begin
                  pend_valid_in = 1'b0;
                  if (pend_ttl_ff != '0 && !hit_ff) begin
                     rec_en         = 1'b1;
                     rec_origin     = pend_origin_ff;
                     rec_seq        = pend_seq_ff;
                     send_valid_in  = 1'b1;
                     send_origin_in = pend_origin_ff;
                     send_sender_in = node_id_ff;
                     send_seq_in    = pend_seq_ff;
                     send_ttl_in    = pend_ttl_ff - 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      pend_origin_ff   <= pend_origin_in;
      pend_seq_ff      <= pend_seq_in;
      pend_ttl_ff      <= pend_ttl_in;
      pend_deadline_ff <= pend_deadline_in;
      if (reset) begin
         pend_valid_ff <= 1'b0;
         next_seq_ff   <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         next_seq_ff   <= next_seq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.commit) begin
         send_valid_ff  <= send_valid_in;
         send_origin_ff <= send_origin_in;
         send_sender_ff <= send_sender_in;
         send_seq_ff    <= send_seq_in;
         send_ttl_ff    <= send_ttl_in;
         duplicate_ff   <= duplicate_in;
         cancelled_ff   <= cancelled_in;
         accepted_ff    <= accepted_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_send_valid  = send_valid_ff;
   assign rsp_send_origin = send_origin_ff;
   assign rsp_send_sender = send_sender_ff;
   assign rsp_send_seq    = send_seq_ff;
   assign rsp_send_ttl    = send_ttl_ff;
   assign rsp_duplicate   = duplicate_ff;
   assign rsp_cancelled   = cancelled_ff;
   assign rsp_accepted    = accepted_ff;

   `MFRD_ASSERT_NEXT(a_commit_loads_result, cmd.commit, rsp_valid_ff)
   `MFRD_ASSERT_IMP(a_cancel_only_on_dup, rsp_valid_ff && cancelled_ff, duplicate_ff)
   `MFRD_ASSERT_IMP(a_send_excludes_rx_flags, rsp_valid_ff && send_valid_ff,
                    !duplicate_ff && !accepted_ff)

endmodule

`default_nettype wire

/* rtl/mesh_flood_relay_dedup.sv */
`default_nettype none

// Flood relay for one mesh node with a duplicate cache of recently sent
// (origin, sequence) pairs. Each transaction on req_ is a receive, an
// originate or a poll, and it yields exactly one result on rsp_. Every
// transaction walks the whole cache through the single read port of the
// cache RAM, one entry per cycle, and the next transaction is accepted only
// once that walk, a drain state and a commit state are over. The result
// sits in an output register, so the next transaction is accepted while an
// earlier result still waits on rsp_ready; that next transaction then holds
// in its commit state until the output register is free. The cache reads as
// all zero after reset, so origin 0 with sequence 0 is treated as seen until
// every slot has been written.
// The node id (index 0) and the hop limit of originated packets (index 1)
// are written through csr_, which is always ready, and may be changed only
// while the block is idle.
module mesh_flood_relay_dedup (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [mfrd_pkg::FUNC_W-1:0]      req_func,
   input  wire logic [mfrd_pkg::ORIGIN_W-1:0]    req_pkt_origin,
   input  wire logic [mfrd_pkg::SEQ_W-1:0]       req_pkt_seq,
   input  wire logic [mfrd_pkg::TTL_W-1:0]       req_pkt_ttl,
   input  wire logic [mfrd_pkg::TIME_W-1:0]      req_now_ms,
   input  wire logic [mfrd_pkg::DELAY_W-1:0]     req_relay_delay,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_send_valid,
   output logic      [mfrd_pkg::ORIGIN_W-1:0]    rsp_send_origin,
   output logic      [mfrd_pkg::ORIGIN_W-1:0]    rsp_send_sender,
   output logic      [mfrd_pkg::SEQ_W-1:0]       rsp_send_seq,
   output logic      [mfrd_pkg::TTL_W-1:0]       rsp_send_ttl,
   output logic                                  rsp_duplicate,
   output logic                                  rsp_cancelled,
   output logic                                  rsp_accepted,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [mfrd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [mfrd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   mfrd_pkg::mfrd_cmd_type cmd;
   mfrd_pkg::mfrd_sts_type sts;

   assign csr_ready = 1'b1;

   mfrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mfrd_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_func        (req_func),
      .req_pkt_origin  (req_pkt_origin),
      .req_pkt_seq     (req_pkt_seq),
      .req_pkt_ttl     (req_pkt_ttl),
      .req_now_ms      (req_now_ms),
      .req_relay_delay (req_relay_delay),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_send_valid  (rsp_send_valid),
      .rsp_send_origin (rsp_send_origin),
      .rsp_send_sender (rsp_send_sender),
      .rsp_send_seq    (rsp_send_seq),
      .rsp_send_ttl    (rsp_send_ttl),
      .rsp_duplicate   (rsp_duplicate),
      .rsp_cancelled   (rsp_cancelled),
      .rsp_accepted    (rsp_accepted)
   );

endmodule

`default_nettype wire

/* dv/mfrd_relay_checker.sv */
`default_nettype none

// Watches the request, response and register channels of the flood relay,
// keeps its own copy of the node state and compares every response with
// the outcome predicted for the oldest outstanding request.
module mfrd_relay_checker
   import mfrd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic [FUNC_W-1:0]     req_func,
   input  wire logic [ORIGIN_W-1:0]   req_pkt_origin,
   input  wire logic [SEQ_W-1:0]      req_pkt_seq,
   input  wire logic [TTL_W-1:0]      req_pkt_ttl,
   input  wire logic [TIME_W-1:0]     req_now_ms,
   input  wire logic [DELAY_W-1:0]    req_relay_delay,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic                  rsp_send_valid,
   input  wire logic [ORIGIN_W-1:0]   rsp_send_origin,
   input  wire logic [ORIGIN_W-1:0]   rsp_send_sender,
   input  wire logic [SEQ_W-1:0]      rsp_send_seq,
   input  wire logic [TTL_W-1:0]      rsp_send_ttl,
   input  wire logic                  rsp_duplicate,
   input  wire logic                  rsp_cancelled,
   input  wire logic                  rsp_accepted,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         fail_count,
   output int                         outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                send_valid;
      logic [ORIGIN_W-1:0] send_origin;
      logic [ORIGIN_W-1:0] send_sender;
      logic [SEQ_W-1:0]    send_seq;
      logic [TTL_W-1:0]    send_ttl;
      logic                duplicate;
      logic                cancelled;
      logic                accepted;
   } relay_outcome_type;

   logic [ORIGIN_W-1:0] my_node_id;
   logic [TTL_W-1:0]    my_hop_limit;
   logic [ORIGIN_W-1:0] seen_origin [CACHE_DEPTH];
   logic [SEQ_W-1:0]    seen_seq [CACHE_DEPTH];
   logic [PTR_W-1:0]    ring_slot;
   logic [SEQ_W-1:0]    seq_counter;
   logic                relay_armed;
   logic [ORIGIN_W-1:0] relay_origin;
   logic [SEQ_W-1:0]    relay_seq;
   logic [TTL_W-1:0]    relay_ttl;
   logic [TIME_W-1:0]   relay_due;

   relay_outcome_type outcome_q[$];
   relay_outcome_type got_rsp;
   relay_outcome_type want_rsp;
   int                failures = 0;

   function automatic logic pair_seen(input logic [ORIGIN_W-1:0] origin,
                                      input logic [SEQ_W-1:0] seq);
      for (int i = 0; i < CACHE_DEPTH; i++) begin
         if (seen_origin[i] == origin && seen_seq[i] == seq) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void remember_pair(input logic [ORIGIN_W-1:0] origin,
                                         input logic [SEQ_W-1:0] seq);
      seen_origin[ring_slot] = origin;
      seen_seq[ring_slot]    = seq;
      ring_slot              = ring_slot + 1'b1;
   endfunction

   // Applies one request to the node state and returns what the node answers.
   function automatic relay_outcome_type node_response(
      input logic [FUNC_W-1:0]   func,
      input logic [ORIGIN_W-1:0] origin,
      input logic [SEQ_W-1:0]    seq,
      input logic [TTL_W-1:0]    ttl,
      input logic [TIME_W-1:0]   now,
      input logic [DELAY_W-1:0]  delay);
      relay_outcome_type r;
      logic [SEQ_W-1:0] fresh_seq;
      r = '0;
      case (func)
         FUNC_RECEIVE: begin
            if (pair_seen(origin, seq)) begin
               r.duplicate = 1'b1;
               if (relay_armed && relay_origin == origin && relay_seq == seq) begin
                  relay_armed = 1'b0;
                  r.cancelled = 1'b1;
               end
            end else begin
               relay_armed  = 1'b1;
               relay_origin = origin;
               relay_seq    = seq;
               relay_ttl    = ttl;
               relay_due    = now + TIME_W'(delay);
               r.accepted   = 1'b1;
            end
         end
         FUNC_ORIGINATE: begin
            fresh_seq   = seq_counter;
            seq_counter = seq_counter + 1'b1;
            remember_pair(my_node_id, fresh_seq);
            r.send_valid  = 1'b1;
            r.send_origin = my_node_id;
            r.send_sender = my_node_id;
            r.send_seq    = fresh_seq;
            r.send_ttl    = my_hop_limit;
         end
         FUNC_POLL: begin
            if (relay_armed && now >= relay_due) begin
               relay_armed = 1'b0;
               // A relay with no hops left, or one already heard, is dropped.
               if (relay_ttl != '0 && !pair_seen(relay_origin, relay_seq)) begin
                  remember_pair(relay_origin, relay_seq);
                  r.send_valid  = 1'b1;
                  r.send_origin = relay_origin;
                  r.send_sender = my_node_id;
                  r.send_seq    = relay_seq;
                  r.send_ttl    = relay_ttl - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         my_node_id   = NODE_ID_RESET;
         my_hop_limit = HOP_LIMIT_RESET;
         for (int i = 0; i < CACHE_DEPTH; i++) begin
            seen_origin[i] = '0;
            seen_seq[i]    = '0;
         end
         ring_slot    = '0;
         seq_counter  = '0;
         relay_armed  = 1'b0;
         relay_origin = '0;
         relay_seq    = '0;
         relay_ttl    = '0;
         relay_due    = '0;
         outcome_q.delete();
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NODE_ID:   my_node_id = csr_wdata[ORIGIN_W-1:0];
               CSR_HOP_LIMIT: my_hop_limit = csr_wdata[TTL_W-1:0];
               default: begin
               end
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got_rsp = '{rsp_send_valid, rsp_send_origin, rsp_send_sender, rsp_send_seq,
                        rsp_send_ttl, rsp_duplicate, rsp_cancelled, rsp_accepted};
            if (outcome_q.size() == 0) begin
               if (failures < 10) begin
                  $display("%0t: response with no request outstanding", $realtime);
               end
               failures++;
            end else begin
               want_rsp = outcome_q.pop_front();
               if (got_rsp !== want_rsp) begin
                  if (failures < 10) begin
                     $display("%0t: mismatch, expected send=%b origin=%h sender=%h seq=%h",
                              $realtime, want_rsp.send_valid, want_rsp.send_origin,
                              want_rsp.send_sender, want_rsp.send_seq);
                     $display("   ttl=%h dup=%b cancel=%b accept=%b",
                              want_rsp.send_ttl, want_rsp.duplicate, want_rsp.cancelled,
                              want_rsp.accepted);
                     $display("   actual send=%b origin=%h sender=%h seq=%h",
                              got_rsp.send_valid, got_rsp.send_origin,
                              got_rsp.send_sender, got_rsp.send_seq);
                     $display("   ttl=%h dup=%b cancel=%b accept=%b",
                              got_rsp.send_ttl, got_rsp.duplicate, got_rsp.cancelled,
                              got_rsp.accepted);
                  end
                  failures++;
               end
            end
         end
         if (req_valid && req_ready) begin
            outcome_q.push_back(node_response(req_func, req_pkt_origin, req_pkt_seq,
                                              req_pkt_ttl, req_now_ms, req_relay_delay));
         end
         outstanding <= outcome_q.size();
      end
      fail_count <= failures;
   end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`default_nettype none

module tb_top
   import mfrd_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS   = 305;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [FUNC_W-1:0]     req_func;
   logic [ORIGIN_W-1:0]   req_pkt_origin;
   logic [SEQ_W-1:0]      req_pkt_seq;
   logic [TTL_W-1:0]      req_pkt_ttl;
   logic [TIME_W-1:0]     req_now_ms;
   logic [DELAY_W-1:0]    req_relay_delay;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_send_valid;
   logic [ORIGIN_W-1:0]   rsp_send_origin;
   logic [ORIGIN_W-1:0]   rsp_send_sender;
   logic [SEQ_W-1:0]      rsp_send_seq;
   logic [TTL_W-1:0]      rsp_send_ttl;
   logic                  rsp_duplicate;
   logic                  rsp_cancelled;
   logic                  rsp_accepted;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    outstanding;

   int                    items_sent = 0;
   int                    burst_left = 8;
   logic [SEQ_W-1:0]      originated = '0;
   logic [TIME_W-1:0]     clock_ms = '0;
   logic [ORIGIN_W-1:0]   cur_node = NODE_ID_RESET;

   mesh_flood_relay_dedup uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_pkt_origin  (req_pkt_origin),
      .req_pkt_seq     (req_pkt_seq),
      .req_pkt_ttl     (req_pkt_ttl),
      .req_now_ms      (req_now_ms),
      .req_relay_delay (req_relay_delay),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_send_valid  (rsp_send_valid),
      .rsp_send_origin (rsp_send_origin),
      .rsp_send_sender (rsp_send_sender),
      .rsp_send_seq    (rsp_send_seq),
      .rsp_send_ttl    (rsp_send_ttl),
      .rsp_duplicate   (rsp_duplicate),
      .rsp_cancelled   (rsp_cancelled),
      .rsp_accepted    (rsp_accepted),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   mfrd_relay_checker relay_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_pkt_origin  (req_pkt_origin),
      .req_pkt_seq     (req_pkt_seq),
      .req_pkt_ttl     (req_pkt_ttl),
      .req_now_ms      (req_now_ms),
      .req_relay_delay (req_relay_delay),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_send_valid  (rsp_send_valid),
      .rsp_send_origin (rsp_send_origin),
      .rsp_send_sender (rsp_send_sender),
      .rsp_send_seq    (rsp_send_seq),
      .rsp_send_ttl    (rsp_send_ttl),
      .rsp_duplicate   (rsp_duplicate),
      .rsp_cancelled   (rsp_cancelled),
      .rsp_accepted    (rsp_accepted),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .outstanding     (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #25_000_000;
      $display("FAILURE");
      $finish;
   end

   // Offers one transaction and holds it until it is taken. Bursts of
   // transactions are separated by idle gaps of random length.
   task automatic put_item(input logic [FUNC_W-1:0]   func,
                           input logic [ORIGIN_W-1:0] origin,
                           input logic [SEQ_W-1:0]    seq,
                           input logic [TTL_W-1:0]    ttl,
                           input logic [TIME_W-1:0]   now,
                           input logic [DELAY_W-1:0]  delay);
      int gap;
      req_valid       <= 1'b1;
      req_func        <= func;
      req_pkt_origin  <= origin;
      req_pkt_seq     <= seq;
      req_pkt_ttl     <= ttl;
      req_now_ms      <= now;
      req_relay_delay <= delay;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (func == FUNC_ORIGINATE) begin
         originated++;
      end
      burst_left--;
      if (burst_left <= 0) begin
         if ($urandom_range(0, 9) == 0) begin
            burst_left = $urandom_range(60, 120);
            gap = 0;
         end else begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stops offering and waits until every response has come back.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   function automatic logic [ORIGIN_W-1:0] pick_origin();
      case ($urandom_range(0, 5))
         0:       return '0;
         1, 2:    return cur_node;
         3, 4:    return ORIGIN_W'($urandom_range(1, 4));
         default: return ORIGIN_W'($urandom);
      endcase
   endfunction

   function automatic logic [SEQ_W-1:0] pick_seq();
      case ($urandom_range(0, 3))
         0, 1:    return SEQ_W'($urandom_range(0, 7));
         2:       return originated - SEQ_W'($urandom_range(1, 5));
         default: return SEQ_W'($urandom);
      endcase
   endfunction

   // A packet heard, possibly polled early, then polled once due; sometimes a
   // rival packet replaces it and sometimes the same packet is heard again.
   task automatic relay_sequence();
      logic [ORIGIN_W-1:0] o;
      logic [SEQ_W-1:0]    s;
      logic [TTL_W-1:0]    t;
      logic [DELAY_W-1:0]  d;
      logic [TIME_W-1:0]   due;
      o = pick_origin();
      s = pick_seq();
      t = ($urandom_range(0, 5) == 0) ? '0 : TTL_W'($urandom);
      d = DELAY_W'($urandom_range(100, 499));
      put_item(FUNC_RECEIVE, o, s, t, clock_ms, d);
      due = clock_ms + TIME_W'(d);
      repeat ($urandom_range(0, 2)) begin
         put_item(FUNC_POLL, ORIGIN_W'($urandom), SEQ_W'($urandom), TTL_W'($urandom),
                  due - 1 - TIME_W'($urandom_range(0, 99)), DELAY_W'($urandom));
      end
      if ($urandom_range(0, 3) == 0) begin
         put_item(FUNC_RECEIVE, pick_origin(), SEQ_W'($urandom), TTL_W'($urandom),
                  clock_ms + 5, DELAY_W'($urandom_range(100, 499)));
      end
      clock_ms = due + TIME_W'($urandom_range(0, 3));
      put_item(FUNC_POLL, ORIGIN_W'($urandom), SEQ_W'($urandom), TTL_W'($urandom),
               clock_ms, DELAY_W'($urandom));
      if ($urandom_range(0, 2) == 0) begin
         put_item(FUNC_RECEIVE, o, s, t, clock_ms, d);
      end
   endtask

   // The node's own next packet is heard first and then originated, so the
   // pending relay is either cancelled by an echo or dropped when polled.
   task automatic cancel_sequence();
      logic [SEQ_W-1:0]   s;
      logic [DELAY_W-1:0] d;
      s = originated;
      d = DELAY_W'($urandom_range(100, 499));
      put_item(FUNC_RECEIVE, cur_node, s, TTL_W'($urandom_range(1, 255)), clock_ms, d);
      put_item(FUNC_ORIGINATE, ORIGIN_W'($urandom), SEQ_W'($urandom), TTL_W'($urandom),
               clock_ms, DELAY_W'($urandom));
      if ($urandom_range(0, 1) == 0) begin
         put_item(FUNC_RECEIVE, cur_node, s, TTL_W'($urandom), clock_ms + 1, d);
      end else begin
         clock_ms = clock_ms + TIME_W'(d);
         put_item(FUNC_POLL, ORIGIN_W'($urandom), SEQ_W'($urandom), TTL_W'($urandom),
                  clock_ms, DELAY_W'($urandom));
      end
   endtask

   task automatic run_scenario();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         relay_sequence();
      end else if (pick < 45) begin
         cancel_sequence();
      end else if (pick < 60) begin
         put_item(FUNC_ORIGINATE, ORIGIN_W'($urandom), SEQ_W'($urandom), TTL_W'($urandom),
                  TIME_W'($urandom), DELAY_W'($urandom));
      end else if (pick < 80) begin
         put_item(FUNC_RECEIVE, pick_origin(), pick_seq(), TTL_W'($urandom), clock_ms,
                  DELAY_W'($urandom_range(100, 499)));
      end else if (pick < 90) begin
         clock_ms = clock_ms + TIME_W'($urandom_range(0, 600));
         put_item(FUNC_POLL, ORIGIN_W'($urandom), SEQ_W'($urandom), TTL_W'($urandom),
                  clock_ms, DELAY_W'($urandom));
      end else begin
         put_item(FUNC_W'($urandom_range(0, 3)), ORIGIN_W'($urandom), SEQ_W'($urandom),
                  TTL_W'($urandom), TIME_W'($urandom), DELAY_W'($urandom));
      end
   endtask

   // The receiver alternates ready runs and stalls; at least one stall is long
   // enough to back the block up into its request side.
   initial begin
      int run_len;
      int hold_len;
      int pattern_count;
      pattern_count = 0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         pattern_count++;
         run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 12);
         if (pattern_count == 150 || $urandom_range(0, 199) == 0) begin
            hold_len = 400;
         end else begin
            case ($urandom_range(0, 3))
               0:       hold_len = 0;
               1:       hold_len = $urandom_range(1, 3);
               default: hold_len = $urandom_range(4, 30);
            endcase
         end
         rsp_ready <= 1'b1;
         repeat (run_len) @(posedge clock);
         if (hold_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_len) @(posedge clock);
         end
      end
   end

   initial begin
      logic [ORIGIN_W-1:0]   node_val;
      logic [CSR_DATA_W-1:0] ttl_word;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_func        <= FUNC_RECEIVE;
      req_pkt_origin  <= '0;
      req_pkt_seq     <= '0;
      req_pkt_ttl     <= '0;
      req_now_ms      <= '0;
      req_relay_delay <= '0;
      csr_valid       <= 1'b0;
      csr_index       <= CSR_NODE_ID;
      csr_wdata       <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset configuration (node 1, hop limit 3).
      // The cleared cache already holds origin 0 with sequence 0.
      put_item(FUNC_RECEIVE, '0, '0, '0, '0, '0);
      put_item(FUNC_POLL, '0, '0, '0, '0, '0);
      put_item(FUNC_UNUSED, '1, '1, '1, '1, '1);
      put_item(FUNC_RECEIVE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 32'd100, 9'd499);
      put_item(FUNC_POLL, '0, '0, '0, 32'd598, '0);
      put_item(FUNC_POLL, '0, '0, '0, 32'd599, '0);
      put_item(FUNC_RECEIVE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 32'd700, 9'd100);
      // A due relay with no hops left is dropped without sending.
      put_item(FUNC_RECEIVE, 32'd5, 16'd7, 8'd0, 32'd1000, 9'd0);
      put_item(FUNC_POLL, '0, '0, '0, 32'd1000, '0);
      // Hearing our own next packet, then sending it, then hearing the echo.
      put_item(FUNC_RECEIVE, NODE_ID_RESET, 16'd0, 8'd4, 32'd2000, 9'd100);
      put_item(FUNC_ORIGINATE, '0, '0, '0, 32'd2001, '0);
      put_item(FUNC_RECEIVE, NODE_ID_RESET, 16'd0, 8'd4, 32'd2002, 9'd100);
      put_item(FUNC_POLL, '0, '0, '0, 32'd5000, '0);
      // A relay whose pair entered the cache before it fell due.
      put_item(FUNC_RECEIVE, NODE_ID_RESET, 16'd1, 8'd9, 32'd3000, 9'd511);
      put_item(FUNC_ORIGINATE, '0, '0, '0, 32'd3001, '0);
      put_item(FUNC_POLL, '0, '0, '0, 32'd4000, '0);
      // Deadlines that wrap past the top of the millisecond counter, and a
      // second packet replacing the pending one.
      put_item(FUNC_RECEIVE, 32'hAAAA_5555, 16'h5AA5, 8'h80, 32'hFFFF_FF00, 9'd511);
      put_item(FUNC_RECEIVE, 32'h1234_5678, 16'h00FF, 8'h01, 32'hFFFF_FF80, 9'd256);
      put_item(FUNC_POLL, '0, '0, '0, 32'h0000_007F, '0);
      put_item(FUNC_POLL, '0, '0, '0, 32'h0000_0080, '0);
      put_item(FUNC_ORIGINATE, '1, '1, '1, '1, '1);
      put_item(FUNC_POLL, '0, '0, '0, '0, '0);
      clock_ms = 32'd10_000;
      settle();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               node_val = ORIGIN_W'($urandom);
               ttl_word = $urandom;
            end
            1: begin
               node_val = '0;
               ttl_word = '0;
            end
            2: begin
               node_val = '1;
               ttl_word = 32'h0000_00FF;
               clock_ms = 32'hFFFF_F000;
            end
            3: begin
               node_val = ORIGIN_W'($urandom);
               ttl_word = 32'd1;
               clock_ms = $urandom;
            end
            default: begin
               node_val = NODE_ID_RESET;
               ttl_word = CSR_DATA_W'(HOP_LIMIT_RESET);
            end
         endcase
         csr_write(CSR_NODE_ID, node_val);
         csr_write(CSR_HOP_LIMIT, ttl_word);
         csr_valid <= 1'b0;
         cur_node = node_val;
         while (items_sent < 25 + (phase + 1) * PHASE_ITEMS) begin
            run_scenario();
         end
         settle();
      end

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
